// ===== design/dmpt_pkg.sv =====
// dmpt_pkg: shared types and constants for the direct-mapped position table
// transaction structs, slot layout, command codes and controller states
// no dependencies
`default_nettype none

package dmpt_pkg;

    typedef enum logic [1:0] {
        KIND_STORE     = 2'd0,
        KIND_PROBE     = 2'd1,
        KIND_CLEAR     = 2'd2,
        KIND_OCCUPANCY = 2'd3
    } kind_t;

    localparam logic [1:0]  FLAG_NONE         = 2'd0;
    localparam logic [7:0]  MIN_REPLACE_DEPTH = 8'd4;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

    typedef struct packed {
        kind_t              kind;
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         bound_flag;
        logic [15:0]        move_code;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] found_score;
        logic [7:0]         found_depth;
        logic [1:0]         found_flag;
        logic [15:0]        found_move;
        logic [31:0]        filled_writes;
        logic [31:0]        lookups_done;
        logic [10:0]        occupancy;
    } result_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [15:0]        move;
    } payload_t;

    typedef struct packed {
        logic [63:0] key;
        payload_t    payload;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OCC,
        ST_OCC_LAST
    } state_t;

endpackage

`default_nettype wire

// ===== design/direct_mapped_position_table_unit.sv =====
// direct_mapped_position_table_unit: top level of the position table
// controller with counters and result register around dmpt_slot_ram
// depends on dmpt_pkg and dmpt_slot_ram
//
// A transaction is taken when start is high and busy is low. Store and probe
// do one slot memory read, then compare and, for a store, write back. Clear
// writes one slot per cycle through the single write port. Occupancy reads the
// first min(SAMPLE_COUNT, 2^INDEX_BITS) slots, one slot read per cycle. After
// reset, busy stays high while the memory is swept to zero; no result is given
// for that sweep. Every transaction gives one result, held on result for one
// cycle with done high; the receiver cannot stall it, so it must take it in
// that cycle.
`default_nettype none

module direct_mapped_position_table_unit #(
    parameter int INDEX_BITS   = 12,
    parameter int SAMPLE_COUNT = 1000
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire dmpt_pkg::cmd_t  cmd,
    output logic                 busy,
    output logic                 done,
    output dmpt_pkg::result_t    result
);

    localparam int SlotCount = 1 << INDEX_BITS;
    localparam int SampleN   = (SAMPLE_COUNT < SlotCount) ? SAMPLE_COUNT : SlotCount;
    localparam logic [INDEX_BITS-1:0] SlotLast   = INDEX_BITS'(SlotCount - 1);
    localparam logic [INDEX_BITS-1:0] SampleLast = INDEX_BITS'(SampleN - 1);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == dmpt_pkg::COUNT_MAX) ? v : v + 32'd1;
    endfunction

    dmpt_pkg::state_t        state_reg, state_next;
    logic [INDEX_BITS-1:0]   walk_reg, walk_next;
    logic                    occ_valid_reg, occ_valid_next;
    logic [10:0]             occ_cnt_reg, occ_cnt_next;
    logic [31:0]             fill_reg, fill_next;
    logic [31:0]             probe_reg, probe_next;
    logic                    clr_cmd_reg, clr_cmd_next;
    logic                    done_reg, done_next;
    dmpt_pkg::cmd_t          cmd_reg, cmd_next;
    dmpt_pkg::result_t       result_reg, result_next;

    logic                    wr_en;
    logic [INDEX_BITS-1:0]   wr_addr;
    dmpt_pkg::slot_t         wr_data;
    logic                    rd_en;
    logic [INDEX_BITS-1:0]   rd_addr;
    dmpt_pkg::slot_t         rd_data;

    logic                    replace;
    logic                    occupied;

    dmpt_slot_ram #(
        .INDEX_BITS (INDEX_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != dmpt_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign replace  = (rd_data.key != cmd_reg.key)
                   || ((rd_data.payload.depth < cmd_reg.depth)
                       && (cmd_reg.depth > dmpt_pkg::MIN_REPLACE_DEPTH));
    assign occupied = occ_valid_reg && (rd_data.payload.flag != dmpt_pkg::FLAG_NONE);

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        occ_valid_next = occ_valid_reg;
        occ_cnt_next   = occ_cnt_reg;
        fill_next      = fill_reg;
        probe_next     = probe_reg;
        clr_cmd_next   = clr_cmd_reg;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = walk_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cmd.key[INDEX_BITS-1:0];

        case (state_reg)
            dmpt_pkg::ST_CLEAR:
            begin
                wr_en     = 1'b1;
                walk_next = INDEX_BITS'(walk_reg + 1'b1);
                if (walk_reg == SlotLast)
                begin
                    state_next   = dmpt_pkg::ST_IDLE;
                    walk_next    = '0;
                    clr_cmd_next = 1'b0;
                    if (clr_cmd_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        result_next.filled_writes = fill_reg;
                        result_next.lookups_done  = probe_reg;
                    end
                end
            end

            dmpt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.kind)
                        dmpt_pkg::KIND_STORE,
                        dmpt_pkg::KIND_PROBE:
                        begin
                            rd_en      = 1'b1;
                            state_next = dmpt_pkg::ST_LOOKUP;
                        end
                        dmpt_pkg::KIND_CLEAR:
                        begin
                            fill_next    = '0;
                            clr_cmd_next = 1'b1;
                            walk_next    = '0;
                            state_next   = dmpt_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            occ_cnt_next   = '0;
                            occ_valid_next = 1'b0;
                            walk_next      = '0;
                            state_next     = dmpt_pkg::ST_OCC;
                        end
                    endcase
                end
            end

            dmpt_pkg::ST_LOOKUP:
            begin
                result_next = '0;
                if (cmd_reg.kind == dmpt_pkg::KIND_STORE)
                begin
                    if (replace)
                    begin
                        wr_en                  = 1'b1;
                        wr_addr                = cmd_reg.key[INDEX_BITS-1:0];
                        wr_data.key            = cmd_reg.key;
                        wr_data.payload.score  = cmd_reg.score;
                        wr_data.payload.depth  = cmd_reg.depth;
                        wr_data.payload.flag   = cmd_reg.bound_flag;
                        wr_data.payload.move   = cmd_reg.move_code;
                        if (rd_data.payload.flag == dmpt_pkg::FLAG_NONE)
                        begin
                            fill_next = sat_inc(fill_reg);
                        end
                    end
                end
                else
                begin
                    probe_next = sat_inc(probe_reg);
                    if (rd_data.key == cmd_reg.key)
                    begin
                        result_next.hit         = 1'b1;
                        result_next.found_score = rd_data.payload.score;
                        result_next.found_depth = rd_data.payload.depth;
                        result_next.found_flag  = rd_data.payload.flag;
                        result_next.found_move  = rd_data.payload.move;
                    end
                end
                result_next.filled_writes = fill_next;
                result_next.lookups_done  = probe_next;
                done_next  = 1'b1;
                state_next = dmpt_pkg::ST_IDLE;
            end

            dmpt_pkg::ST_OCC:
            begin
                rd_en          = 1'b1;
                rd_addr        = walk_reg;
                walk_next      = INDEX_BITS'(walk_reg + 1'b1);
                occ_valid_next = 1'b1;
                if (occupied)
                begin
                    occ_cnt_next = occ_cnt_reg + 11'd1;
                end
                if (walk_reg == SampleLast)
                begin
                    walk_next  = '0;
                    state_next = dmpt_pkg::ST_OCC_LAST;
                end
            end

            dmpt_pkg::ST_OCC_LAST:
            begin
                occ_cnt_next   = occupied ? occ_cnt_reg + 11'd1 : occ_cnt_reg;
                occ_valid_next = 1'b0;
                result_next    = '0;
                result_next.filled_writes = fill_reg;
                result_next.lookups_done  = probe_reg;
                result_next.occupancy     = occ_cnt_next;
                done_next  = 1'b1;
                state_next = dmpt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = dmpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmpt_pkg::ST_CLEAR;
            walk_reg      <= '0;
            occ_valid_reg <= 1'b0;
            occ_cnt_reg   <= '0;
            fill_reg      <= '0;
            probe_reg     <= '0;
            clr_cmd_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            occ_valid_reg <= occ_valid_next;
            occ_cnt_reg   <= occ_cnt_next;
            fill_reg      <= fill_next;
            probe_reg     <= probe_next;
            clr_cmd_reg   <= clr_cmd_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== design/dmpt_slot_ram.sv =====
// dmpt_slot_ram: slot memory holding key and payload of every table slot
// one write port, one read port with registered read data
// depends on dmpt_pkg
`default_nettype none

module dmpt_slot_ram #(
    parameter int INDEX_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [INDEX_BITS-1:0]  wr_addr,
    input  wire dmpt_pkg::slot_t        wr_data,
    input  wire logic                   rd_en,
    input  wire logic [INDEX_BITS-1:0]  rd_addr,
    output dmpt_pkg::slot_t             rd_data
);

    localparam int SlotCount = 1 << INDEX_BITS;

    dmpt_pkg::slot_t mem [SlotCount];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/position_table_checker.sv =====
// position_table_checker: watches the command and result channels of the position table,
// keeps its own copy of the slot array and counters, and compares every result in order
// depends on dmpt_pkg
`default_nettype none

module position_table_checker
    import dmpt_pkg::*;
#(
    parameter int INDEX_BITS   = 12,
    parameter int SAMPLE_COUNT = 1000
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire cmd_t    cmd,
    input  wire logic    done,
    input  wire result_t result,
    output int           mismatches,
    output int           pending,
    output int           probe_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = 1 << INDEX_BITS;
    localparam int SAMPLED = (SAMPLE_COUNT < SLOTS) ? SAMPLE_COUNT : SLOTS;

    logic [63:0] slot_key  [SLOTS];
    payload_t    slot_data [SLOTS];
    logic [31:0] fill_count   = '0;
    logic [31:0] lookup_total = '0;
    result_t     awaited_results [$];
    int          errors = 0;
    int          hits   = 0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_key[i]  = '0;
            slot_data[i] = '0;
        end
    end

    function automatic result_t apply_command(input cmd_t c);
        result_t               r;
        logic [INDEX_BITS-1:0] idx;
        int                    occupied;
        r        = '0;
        occupied = 0;
        idx      = c.key[INDEX_BITS-1:0];
        case (c.kind)
            KIND_STORE:
            begin
                if (slot_key[idx] != c.key
                    || (slot_data[idx].depth < c.depth && c.depth > MIN_REPLACE_DEPTH))
                begin
                    if (slot_data[idx].flag == FLAG_NONE && fill_count != COUNT_MAX)
                        fill_count = fill_count + 1;
                    slot_key[idx]  = c.key;
                    slot_data[idx] = '{c.score, c.depth, c.bound_flag, c.move_code};
                end
            end
            KIND_PROBE:
            begin
                if (lookup_total != COUNT_MAX)
                    lookup_total = lookup_total + 1;
                if (slot_key[idx] == c.key)
                begin
                    r.hit         = 1'b1;
                    r.found_score = slot_data[idx].score;
                    r.found_depth = slot_data[idx].depth;
                    r.found_flag  = slot_data[idx].flag;
                    r.found_move  = slot_data[idx].move;
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_key[i]  = '0;
                    slot_data[i] = '0;
                end
                fill_count = '0;
            end
            KIND_OCCUPANCY:
            begin
                for (int i = 0; i < SAMPLED; i++)
                    if (slot_data[i].flag != FLAG_NONE)
                        occupied++;
            end
            default:
            begin
            end
        endcase
        r.filled_writes = fill_count;
        r.lookups_done  = lookup_total;
        r.occupancy     = occupied[10:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result transaction: expected none, actual %0h",
                             $time, result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("hit", want.hit, result.hit);
                    check_field("found_score", want.found_score, result.found_score);
                    check_field("found_depth", want.found_depth, result.found_depth);
                    check_field("found_flag", want.found_flag, result.found_flag);
                    check_field("found_move", want.found_move, result.found_move);
                    check_field("filled_writes", want.filled_writes, result.filled_writes);
                    check_field("lookups_done", want.lookups_done, result.lookups_done);
                    check_field("occupancy", want.occupancy, result.occupancy);
                    if (want.hit)
                        hits++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_results.insert(awaited_results.size(), apply_command(cmd));
            mismatches <= errors;
            pending    <= awaited_results.size();
            probe_hits <= hits;
        end
    end

endmodule

`default_nettype wire

// ===== dv/direct_mapped_position_table_unit_tb.sv =====
// direct_mapped_position_table_unit_tb: drives directed and random command transactions
// into the position table and reports the verdict from the checker's failure and pending counts
// depends on dmpt_pkg, direct_mapped_position_table_unit and position_table_checker
`default_nettype none

module direct_mapped_position_table_unit_tb;
    import dmpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_BITS   = 12;
    localparam int SAMPLE_COUNT = 1000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_TAIL    = 200;
    localparam int POOL_SIZE    = 32;
    localparam int MAX_CLEARS   = 40;
    localparam int MAX_SAMPLES  = 60;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    int mismatches;
    int pending;
    int probe_hits;

    logic [63:0] key_pool [POOL_SIZE];
    cmd_t        directed_cmds [$];
    int          sent_per_kind [4] = '{0, 0, 0, 0};

    always #2 clk = ~clk;

    direct_mapped_position_table_unit #(
        .INDEX_BITS   (INDEX_BITS),
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    position_table_checker #(
        .INDEX_BITS   (INDEX_BITS),
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) table_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending),
        .probe_hits (probe_hits)
    );

    function automatic cmd_t make_cmd(input kind_t k, input logic [63:0] key,
                                      input logic [15:0] score, input logic [7:0] depth,
                                      input logic [1:0] flag, input logic [15:0] mv);
        cmd_t c;
        c.kind       = k;
        c.key        = key;
        c.score      = score;
        c.depth      = depth;
        c.bound_flag = flag;
        c.move_code  = mv;
        return c;
    endfunction

    function automatic void queue_directed(input cmd_t c);
        directed_cmds.insert(directed_cmds.size(), c);
    endfunction

    function automatic cmd_t next_random_cmd();
        cmd_t        c;
        int          pick;
        int          sel;
        logic [63:0] k;
        pick = $urandom_range(0, 199);
        sel  = $urandom_range(0, 19);
        if (sel < 12)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (sel < 16)
        begin
            k = {$urandom, $urandom};
            k[INDEX_BITS-1:0] = key_pool[$urandom_range(0, POOL_SIZE - 1)][INDEX_BITS-1:0];
        end
        else if (sel < 19)
            k = {$urandom, $urandom};
        else
            k = '0;
        c = make_cmd(KIND_PROBE, k, 16'($urandom), 8'($urandom_range(0, 12)),
                     2'($urandom_range(0, 3)), 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            c.depth = 8'($urandom);
        if (pick < 3 && sent_per_kind[KIND_CLEAR] < MAX_CLEARS)
            c.kind = KIND_CLEAR;
        else if (pick < 8 && sent_per_kind[KIND_OCCUPANCY] < MAX_SAMPLES)
            c.kind = KIND_OCCUPANCY;
        else if (pick < 108)
            c.kind = KIND_STORE;
        return c;
    endfunction

    task automatic issue(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sent_per_kind[c.kind]++;
    endtask

    task automatic idle_burst(input int cycles);
        logic [$bits(cmd_t)-1:0] noise;
        noise = ($bits(cmd_t))'({$urandom, $urandom, $urandom, $urandom});
        start <= 1'b0;
        cmd   <= noise;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_all();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] k1;
        logic [63:0] k2;
        int          guard;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (i >= POOL_SIZE / 2)
                key_pool[i][INDEX_BITS-1:0] = key_pool[i - POOL_SIZE / 2][INDEX_BITS-1:0];
            else if ($urandom_range(0, 9) == 0)
                key_pool[i][INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(1000, 4095));
            else
                key_pool[i][INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(0, 999));
        end
        k1 = 64'h0123_4567_89AB_C005;
        k2 = 64'hFEDC_BA98_7654_3005;

        queue_directed(make_cmd(KIND_PROBE, '0, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_PROBE, '1, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_STORE, '1, 16'h7FFF, 8'd255, 2'd3, 16'hFFFF));
        queue_directed(make_cmd(KIND_PROBE, '1, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_STORE, k1, 16'h8000, 8'd3, 2'd1, 16'h0000));
        queue_directed(make_cmd(KIND_STORE, k1, 16'h1234, 8'd4, 2'd2, 16'h1111));
        queue_directed(make_cmd(KIND_STORE, k1, 16'h2345, 8'd2, 2'd2, 16'h2222));
        queue_directed(make_cmd(KIND_STORE, k1, 16'hFFFF, 8'd5, 2'd2, 16'h3333));
        queue_directed(make_cmd(KIND_PROBE, k1, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_STORE, k2, 16'h0001, 8'd0, FLAG_NONE, 16'h4444));
        queue_directed(make_cmd(KIND_STORE, k1, 16'h0002, 8'd1, 2'd1, 16'h5555));
        queue_directed(make_cmd(KIND_PROBE, k2, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_STORE, '0, 16'h0003, 8'd0, FLAG_NONE, 16'h6666));
        queue_directed(make_cmd(KIND_STORE, '0, 16'h0004, 8'd9, 2'd2, 16'h7777));
        queue_directed(make_cmd(KIND_OCCUPANCY, '0, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_STORE, 64'd999, 16'h0005, 8'd6, 2'd1, 16'h8888));
        queue_directed(make_cmd(KIND_STORE, 64'd1000, 16'h0006, 8'd7, 2'd1, 16'h9999));
        queue_directed(make_cmd(KIND_STORE, {16{4'hA}}, 16'hAAAA, 8'hAA, 2'd2, 16'hAAAA));
        queue_directed(make_cmd(KIND_STORE, {16{4'h5}}, 16'h5555, 8'h55, 2'd1, 16'h5555));
        queue_directed(make_cmd(KIND_OCCUPANCY, '0, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_CLEAR, '0, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_PROBE, k1, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_PROBE, '0, '0, '0, FLAG_NONE, '0));
        queue_directed(make_cmd(KIND_OCCUPANCY, '0, '0, '0, FLAG_NONE, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cmds[i])
            issue(directed_cmds[i]);
        drain_all();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_all();
            if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0)
                idle_burst($urandom_range(1, 19));
            issue(next_random_cmd());
        end

        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);

        if (pending != 0)
            $display("%0t %0d expected results never arrived", $time, pending);
        $display("covered %0d stores, %0d probes (%0d hits), %0d clears, %0d occupancy samples",
                 sent_per_kind[KIND_STORE], sent_per_kind[KIND_PROBE], probe_hits,
                 sent_per_kind[KIND_CLEAR], sent_per_kind[KIND_OCCUPANCY]);
        $display("with key collisions, depth replacement rules and empty-slot key 0 probes");
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting on the table");
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
